// ===== sv/clr_pkg.sv =====
// Shared types and constants for the clipped line rasterizer.
// No dependencies; imported by clr_core and clipped_line_rasterizer.
package clr_pkg;
  localparam logic [1:0] CMD_LINE  = 2'd0;
  localparam logic [1:0] CMD_PLOT  = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;
  localparam logic [1:0] CMD_CLEAR = 2'd3;

  localparam logic [3:0] OC_LEFT   = 4'd1;
  localparam logic [3:0] OC_RIGHT  = 4'd2;
  localparam logic [3:0] OC_TOP    = 4'd4;
  localparam logic [3:0] OC_BOTTOM = 4'd8;

  localparam int CLIP_PASS_LIMIT = 8;
  localparam logic [8:0] COUNT_MAX = 9'd511;

  // Coordinates during clipping stay within 18 signed bits.
  localparam int CW = 18;
  typedef logic signed [CW-1:0] coord_t;

  // Result bundle between core and top level.
  typedef struct packed {
    logic       accepted;
    logic [8:0] pixels_written;
    logic [7:0] pixel_value;
  } result_t;
endpackage

// ===== sv/clipped_line_rasterizer.sv =====
// Top level: line, plot, read and clear commands on an 8-bit frame buffer.
// A drawn line clips with a 36-step serial divide per clip pass, then walks one pixel
// per step; clear writes zero to every address of the W*H frame store.
// One item at a time: the next is accepted only after the result strobe has ended.
// Reset is synchronous and clears control state only; the frame store is undefined
// until cleared or written. The result strobe lasts one cycle and cannot be stalled.
module clipped_line_rasterizer #(
  parameter int SCREEN_WIDTH  = 320,
  parameter int SCREEN_HEIGHT = 200
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         command,
  input  logic signed [15:0] start_x,
  input  logic signed [15:0] start_y,
  input  logic signed [15:0] end_x,
  input  logic signed [15:0] end_y,
  input  logic [7:0]         ink,
  output logic               strobe,
  output logic               accepted,
  output logic [8:0]         pixels_written,
  output logic [7:0]         pixel_value
);
  import clr_pkg::*;

  logic    idle;
  result_t res;

  // The core holds the frame store and runs one command to completion.
  clr_core #(
    .SCREEN_WIDTH (SCREEN_WIDTH),
    .SCREEN_HEIGHT(SCREEN_HEIGHT)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .go     (start && idle),
    .command(command),
    .start_x(start_x),
    .start_y(start_y),
    .end_x  (end_x),
    .end_y  (end_y),
    .ink    (ink),
    .idle   (idle),
    .done   (strobe),
    .res    (res)
  );

  assign busy           = !idle;
  assign accepted       = res.accepted;
  assign pixels_written = res.pixels_written;
  assign pixel_value    = res.pixel_value;
endmodule

// ===== sv/clr_core.sv =====
// Clipping, line walking and frame store sequencer of the line rasterizer.
// Depends on clr_pkg.
module clr_core #(
  parameter int SCREEN_WIDTH  = 320,
  parameter int SCREEN_HEIGHT = 200
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  go,
  input  logic [1:0]            command,
  input  logic signed [15:0]    start_x,
  input  logic signed [15:0]    start_y,
  input  logic signed [15:0]    end_x,
  input  logic signed [15:0]    end_y,
  input  logic [7:0]            ink,
  output logic                  idle,
  output logic                  done,
  output clr_pkg::result_t      res
);
  import clr_pkg::*;

  localparam int DEPTH = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int XW    = $clog2(SCREEN_WIDTH);
  localparam int YW    = $clog2(SCREEN_HEIGHT);
  // Product of two clip-range differences and its divisor widths.
  localparam int PW    = 2 * CW;
  localparam int DW    = CW;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CODE  = 4'd1;
  localparam logic [3:0] S_MUL   = 4'd2;
  localparam logic [3:0] S_DIV   = 4'd3;
  localparam logic [3:0] S_FIX   = 4'd4;
  localparam logic [3:0] S_SETUP = 4'd5;
  localparam logic [3:0] S_WALK  = 4'd6;
  localparam logic [3:0] S_RDW   = 4'd7;
  localparam logic [3:0] S_RDD   = 4'd8;
  localparam logic [3:0] S_CLR   = 4'd9;
  localparam logic [3:0] S_DONE  = 4'd10;

  logic [7:0] mem [DEPTH];
  logic       mem_we;
  logic [AW-1:0] mem_wa, mem_ra;
  logic [7:0] mem_wd, mem_rd;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    mem_rd <= mem[mem_ra];
  end

  logic [3:0] state;
  coord_t x0, y0, x1, y1;
  logic [3:0] c0, c1;
  logic [3:0] passes;
  logic [7:0] color;
  logic       horiz;      // clipping against a top or bottom edge
  coord_t     edge_v;
  logic signed [PW-1:0] prod;
  logic [PW-1:0] rem_q;   // dividend magnitude, shifted out MSB first
  logic [DW-1:0] rem;     // partial remainder
  logic [DW-1:0] dmag;
  logic [PW-1:0] quo;
  logic       qneg;
  logic [$clog2(PW+1)-1:0] dcnt;
  coord_t dx, dy, err;
  logic signed [1:0] sx, sy;
  logic [8:0] count;
  logic [AW-1:0] clr_addr;

  function automatic logic [3:0] ocode(coord_t x, coord_t y);
    logic [3:0] c;
    c = '0;
    if (x < 0) c |= OC_LEFT;
    else if (x >= coord_t'(SCREEN_WIDTH)) c |= OC_RIGHT;
    if (y < 0) c |= OC_TOP;
    else if (y >= coord_t'(SCREEN_HEIGHT)) c |= OC_BOTTOM;
    return c;
  endfunction

  function automatic logic inb(coord_t x, coord_t y);
    return x >= 0 && x < coord_t'(SCREEN_WIDTH) && y >= 0 && y < coord_t'(SCREEN_HEIGHT);
  endfunction

  // Row-major address; a single multiply by a constant.
  function automatic logic [AW-1:0] addr_of(coord_t x, coord_t y);
    logic [AW+YW-1:0] a;
    a = (AW+YW)'(y[YW-1:0]) * (AW+YW)'(SCREEN_WIDTH) + (AW+YW)'(x[XW-1:0]);
    return a[AW-1:0];
  endfunction

  logic [3:0] co;
  coord_t     num_a, num_b, den;
  always_comb begin
    co = (c0 != 4'd0) ? c0 : c1;
    if ((co & (OC_BOTTOM | OC_TOP)) != 4'd0) begin
      num_a = x1 - x0;
      num_b = edge_v - y0;
      den   = y1 - y0;
    end else begin
      num_a = y1 - y0;
      num_b = edge_v - x0;
      den   = x1 - x0;
    end
  end

  // Restoring division step on magnitudes: the remainder takes in the next dividend bit.
  logic [DW:0] trial;
  always_comb begin
    trial = {1'b0, rem[DW-2:0], rem_q[PW-1]} - {1'b0, dmag};
  end

  coord_t e2;
  logic   at_end;
  coord_t nx, ny;
  always_comb begin
    e2 = err;
    at_end = (x0 == x1) && (y0 == y1);
    nx = x0;
    ny = y0;
    if (e2 > -dx) nx = x0 + coord_t'(sx);
    if (e2 < dy)  ny = y0 + coord_t'(sy);
  end

  coord_t qv;
  always_comb begin
    qv = qneg ? -coord_t'(quo[CW-1:0]) : coord_t'(quo[CW-1:0]);
  end

  always_comb begin
    mem_we = 1'b0;
    mem_wa = addr_of(x0, y0);
    mem_wd = color;
    mem_ra = addr_of(x0, y0);
    if (state == S_WALK && inb(x0, y0)) begin
      mem_we = 1'b1;
    end
    if (state == S_CLR) begin
      mem_we = 1'b1;
      mem_wa = clr_addr;
      mem_wd = 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      done   <= 1'b0;
      passes <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (go) begin
            x0 <= coord_t'(start_x);
            y0 <= coord_t'(start_y);
            color <= ink;
            res <= '0;
            passes <= '0;
            count <= '0;
            clr_addr <= '0;
            unique case (command)
              CMD_LINE:  state <= S_CODE;
              CMD_PLOT:  state <= S_WALK;
              CMD_READ:  state <= S_RDW;
              CMD_CLEAR: state <= S_CLR;
              default:   state <= S_DONE;
            endcase
            c0 <= ocode(coord_t'(start_x), coord_t'(start_y));
            c1 <= ocode(coord_t'(end_x), coord_t'(end_y));
            x1 <= (command == CMD_PLOT) ? coord_t'(start_x) : coord_t'(end_x);
            y1 <= (command == CMD_PLOT) ? coord_t'(start_y) : coord_t'(end_y);
            dx <= '0;
            dy <= '0;
            err <= '0;
            sx <= 2'sd1;
            sy <= 2'sd1;
          end
        end
        S_CODE: begin
          if ((c0 | c1) == 4'd0) begin
            state <= S_SETUP;
          end else if ((c0 & c1) != 4'd0 || passes >= 4'(CLIP_PASS_LIMIT)) begin
            state <= S_DONE;
          end else begin
            horiz <= (co & (OC_BOTTOM | OC_TOP)) != 4'd0;
            if ((co & OC_BOTTOM) != 4'd0) edge_v <= coord_t'(SCREEN_HEIGHT - 1);
            else if ((co & OC_TOP) != 4'd0) edge_v <= '0;
            else if ((co & OC_RIGHT) != 4'd0) edge_v <= coord_t'(SCREEN_WIDTH - 1);
            else edge_v <= '0;
            passes <= passes + 4'd1;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          if (den == 0) begin
            state <= S_DONE;
          end else begin
            prod <= PW'(num_a) * PW'(num_b);
            dmag <= den[CW-1] ? DW'(-den) : DW'(den);
            qneg <= den[CW-1];
            dcnt <= '0;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (dcnt == '0) begin
            qneg  <= qneg ^ prod[PW-1];
            rem_q <= prod[PW-1] ? PW'(-prod) : PW'(prod);
            rem   <= '0;
            quo   <= '0;
            dcnt  <= dcnt + 1'b1;
          end else if (dcnt <= ($clog2(PW+1))'(PW)) begin
            // One quotient bit per cycle, MSB first.
            if (!trial[DW]) begin
              rem <= trial[DW-1:0];
              quo <= {quo[PW-2:0], 1'b1};
            end else begin
              rem <= {rem[DW-2:0], rem_q[PW-1]};
              quo <= {quo[PW-2:0], 1'b0};
            end
            rem_q <= rem_q << 1;
            dcnt  <= dcnt + 1'b1;
          end else begin
            state <= S_FIX;
          end
        end
        S_FIX: begin
          if (co == c0) begin
            if (horiz) begin
              x0 <= x0 + qv;
              y0 <= edge_v;
              c0 <= ocode(x0 + qv, edge_v);
            end else begin
              y0 <= y0 + qv;
              x0 <= edge_v;
              c0 <= ocode(edge_v, y0 + qv);
            end
          end else begin
            if (horiz) begin
              x1 <= x0 + qv;
              y1 <= edge_v;
              c1 <= ocode(x0 + qv, edge_v);
            end else begin
              y1 <= y0 + qv;
              x1 <= edge_v;
              c1 <= ocode(edge_v, y0 + qv);
            end
          end
          state <= S_CODE;
        end
        S_SETUP: begin
          res.accepted <= 1'b1;
          dx <= (x1 > x0) ? x1 - x0 : x0 - x1;
          dy <= (y1 > y0) ? y1 - y0 : y0 - y1;
          sx <= (x0 < x1) ? 2'sd1 : -2'sd1;
          sy <= (y0 < y1) ? 2'sd1 : -2'sd1;
          if (((x1 > x0) ? x1 - x0 : x0 - x1) > ((y1 > y0) ? y1 - y0 : y0 - y1)) begin
            err <= ((x1 > x0) ? x1 - x0 : x0 - x1) >>> 1;
          end else begin
            err <= -(((y1 > y0) ? y1 - y0 : y0 - y1) >>> 1);
          end
          state <= S_WALK;
        end
        S_WALK: begin
          if (inb(x0, y0)) begin
            if (count != COUNT_MAX) count <= count + 9'd1;
            res.accepted <= 1'b1;
          end
          if (at_end) begin
            state <= S_DONE;
          end else begin
            if (e2 > -dx) err <= err - dy - ((e2 < dy) ? -dx : coord_t'(0));
            else if (e2 < dy) err <= err + dx;
            x0 <= nx;
            y0 <= ny;
          end
        end
        S_RDW: begin
          state <= S_RDD;
        end
        S_RDD: begin
          if (inb(x0, y0)) begin
            res.accepted <= 1'b1;
            res.pixel_value <= mem_rd;
          end
          state <= S_DONE;
        end
        S_CLR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == AW'(DEPTH - 1)) state <= S_DONE;
        end
        S_DONE: begin
          res.pixels_written <= count;
          done <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign idle = (state == S_IDLE) && !done;

`ifndef SYNTHESIS
  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done held longer than one cycle");
  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !mem_we)
    else $error("frame store written while idle");
  a_pass_cap: assert property (@(posedge clk) disable iff (rst)
    passes <= 4'(CLIP_PASS_LIMIT))
    else $error("clip pass count exceeded cap");
`endif
endmodule
